[rtl/bnd_pkg.sv]
package bnd_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int PER_W      = 3;
    localparam int CELLS_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 12;
    localparam int ROWV_W     = 13;

    localparam logic [FW_W-1:0]    FW_RESET    = 12'd640;
    localparam logic [FH_W-1:0]    FH_RESET    = 13'd480;
    localparam logic [PER_W-1:0]   PER_RESET   = 3'd2;
    localparam logic [CELLS_W-1:0] CELLS_RESET = 32'd2308;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_PCOLS  = 3'd2,
        CFG_PROWS  = 3'd3,
        CFG_CELLS  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        COL_RED     = 2'd0,
        COL_GREEN   = 2'd1,
        COL_BLUE    = 2'd2,
        COL_RED_ALT = 2'd3
    } t_colour;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan;
        logic div_start;
        logic div;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic emit_now;
        logic scan_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

[rtl/bnd_controller.sv]
module bnd_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bnd_pkg::t_sts i_sts,
    output bnd_pkg::t_cmd o_cmd
);
    import bnd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.emit_now) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = ST_DRAIN;
            end
            // last tap read lands in the accumulators here
            ST_DRAIN: n_state = ST_LOAD;
            ST_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[rtl/bnd_datapath.sv]
module bnd_datapath #(
    parameter int MAX_WIDTH  = 2048,
    parameter int WINDOW     = 3,
    parameter int MAX_PERIOD = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bnd_pkg::t_cmd                   i_cmd,
    output bnd_pkg::t_sts                   o_sts,
    input  logic                            i_op,
    input  logic [bnd_pkg::PIX_W-1:0]       i_pixel,
    input  logic                            i_cfg_we,
    input  logic [bnd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bnd_pkg::CELLS_W-1:0]     i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [3*bnd_pkg::PIX_W-1:0]     o_out_data,
    output logic                            o_out_last
);
    import bnd_pkg::*;

    localparam int HALF       = WINDOW / 2;
    localparam int STORE_ROWS = WINDOW + 1;
    localparam int TAPS       = WINDOW * WINDOW;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WV         = $clog2(MAX_WIDTH + 1);
    localparam int SLW        = $clog2(STORE_ROWS);
    localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam int PHW        = $clog2(MAX_PERIOD);
    localparam int PV         = $clog2(MAX_PERIOD + 1);
    localparam int DW         = $clog2(WINDOW);
    localparam int LW         = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUMW       = $clog2(255 * TAPS + 1);
    localparam int CNTW       = $clog2(TAPS + 1);
    localparam int SXW        = CW + 2;
    localparam int SYW        = ROW_W + 2;
    localparam int TW         = SUMW + PIX_W;

    // configuration
    logic [FW_W-1:0]    r_fw;
    logic [FH_W-1:0]    r_fh;
    logic [PER_W-1:0]   r_pcols;
    logic [PER_W-1:0]   r_prows;
    logic [CELLS_W-1:0] r_cells;

    logic [WV-1:0]     w_eff;
    logic [ROWV_W-1:0] h_eff;
    logic [PV-1:0]     pc_eff;
    logic [PV-1:0]     pr_eff;

    always_comb begin
        if (r_fw == '0) w_eff = WV'(1);
        else if (32'(r_fw) > 32'(MAX_WIDTH)) w_eff = WV'(MAX_WIDTH);
        else w_eff = WV'(r_fw);
        if (r_fh == '0) h_eff = ROWV_W'(1);
        else if (32'(r_fh) > 32'(MAX_HEIGHT)) h_eff = ROWV_W'(MAX_HEIGHT);
        else h_eff = ROWV_W'(r_fh);
        if (r_pcols == '0) pc_eff = PV'(1);
        else if (32'(r_pcols) > 32'(MAX_PERIOD)) pc_eff = PV'(MAX_PERIOD);
        else pc_eff = PV'(r_pcols);
        if (r_prows == '0) pr_eff = PV'(1);
        else if (32'(r_prows) > 32'(MAX_PERIOD)) pr_eff = PV'(MAX_PERIOD);
        else pr_eff = PV'(r_prows);
    end

    function automatic logic [PHW-1:0] inc_ph(input logic [PHW-1:0] ph, input logic [PV-1:0] p);
        logic [PHW-1:0] res;
        if (PV'(ph) + PV'(1) >= p) res = '0;
        else res = ph + PHW'(1);
        return res;
    endfunction

    function automatic logic [PHW-1:0] dec_ph(input logic [PHW-1:0] ph, input logic [PV-1:0] p);
        logic [PHW-1:0] res;
        if (ph == '0) res = PHW'(p - PV'(1));
        else res = ph - PHW'(1);
        return res;
    endfunction

    function automatic logic [SLW-1:0] inc_sl(input logic [SLW-1:0] s);
        logic [SLW-1:0] res;
        if (s == SLW'(STORE_ROWS - 1)) res = '0;
        else res = s + SLW'(1);
        return res;
    endfunction

    function automatic logic [SLW-1:0] dec_sl(input logic [SLW-1:0] s);
        logic [SLW-1:0] res;
        if (s == '0) res = SLW'(STORE_ROWS - 1);
        else res = s - SLW'(1);
        return res;
    endfunction

    // line store
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    // input and output positions
    logic [CW-1:0]    r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [SLW-1:0]   r_in_slot;
    logic             r_done;
    logic [LW-1:0]    r_lag;
    logic [CW-1:0]    r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic [SLW-1:0]   r_out_slot;
    logic [PHW-1:0]   r_oc_ph;
    logic [PHW-1:0]   r_or_ph;

    // neighbourhood scan
    logic [DW-1:0]         r_dx, r_dy;
    logic signed [SXW-1:0] r_sx, r_sx0;
    logic signed [SYW-1:0] r_sy;
    logic [PHW-1:0]        r_cph, r_cph0, r_rph;
    logic [SLW-1:0]        r_slot;
    logic                  r_tap_go, r_tap_v;
    logic [1:0]            r_tap_col;

    logic [SUMW-1:0] r_sum [3];
    logic [CNTW-1:0] r_cnt [3];

    // divider
    logic [SUMW-1:0]  r_rem;
    logic [PIX_W-1:0] r_q;
    logic [2:0]       r_bit;
    logic [1:0]       r_dcol;
    logic [PIX_W-1:0] r_res [3];

    logic                r_ov;
    logic [3*PIX_W-1:0]  r_odata;
    logic                r_olast;

    // accept decision
    logic          wr_en;
    logic          in_col_wrap, in_row_wrap;
    logic [LW-1:0] thr;

    assign wr_en       = i_cmd.accept && (i_op == OP_PIXEL) && !r_done;
    assign in_col_wrap = (WV'(r_in_col) + WV'(1)) >= w_eff;
    assign in_row_wrap = (ROWV_W'(r_in_row) + ROWV_W'(1)) >= h_eff;
    assign thr         = LW'(HALF) * LW'(w_eff) + LW'(HALF + 1);

    assign o_sts.emit_now = ((i_op == OP_PIXEL) && !r_done)
                          ? (!(in_col_wrap && in_row_wrap) && ((r_lag + LW'(1)) >= thr))
                          : r_done;

    // start of scan, top-left corner of the window
    logic [PHW-1:0] st_cph, st_rph;
    logic [SLW-1:0] st_slot;

    always_comb begin
        st_cph  = r_oc_ph;
        st_rph  = r_or_ph;
        st_slot = r_out_slot;
        for (int k = 0; k < HALF; k++) begin
            st_cph  = dec_ph(st_cph, pc_eff);
            st_rph  = dec_ph(st_rph, pr_eff);
            st_slot = dec_sl(st_slot);
        end
    end

    logic signed [SXW-1:0] w_s;
    logic signed [SYW-1:0] h_s;
    logic                  tap_in;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [1:0]            rp2, cp2;
    logic [1:0]            code;
    logic [1:0]            tap_col;

    assign w_s     = $signed(SXW'(w_eff));
    assign h_s     = $signed(SYW'(h_eff));
    assign tap_in  = (r_sx >= 0) && (r_sx < w_s) && (r_sy >= 0) && (r_sy < h_s);
    assign rd_addr = AW'(r_slot) * AW'(MAX_WIDTH) + AW'(r_sx[CW-1:0]);
    assign wr_addr = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
    assign rp2     = 2'(r_rph);
    assign cp2     = 2'(r_cph);
    assign code    = r_cells[{rp2, cp2, 1'b0} +: 2];
    assign tap_col = (code == COL_RED_ALT) ? COL_RED : code;

    assign o_sts.scan_last = (r_dx == DW'(WINDOW - 1)) && (r_dy == DW'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= i_pixel;
        if (i_cmd.scan) r_rdata <= mem[rd_addr];
    end

    // shared restoring divider, one quotient bit a cycle
    logic [CNTW-1:0]  cnt_sel;
    logic [TW-1:0]    trial;
    logic             ge;
    logic [PIX_W-1:0] q_new;
    logic [SUMW-1:0]  rem_new;

    always_comb begin
        unique case (r_dcol)
            2'd0:    cnt_sel = r_cnt[0];
            2'd1:    cnt_sel = r_cnt[1];
            default: cnt_sel = r_cnt[2];
        endcase
    end

    assign trial   = TW'(cnt_sel) << r_bit;
    assign ge      = TW'(r_rem) >= trial;
    assign q_new   = ge ? (r_q | (PIX_W'(1) << r_bit)) : r_q;
    assign rem_new = ge ? SUMW'(TW'(r_rem) - trial) : r_rem;

    assign o_sts.div_last = (r_bit == 3'd0) && (r_dcol == 2'd2);
    assign o_sts.out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_dx   <= '0;
            r_dy   <= '0;
            r_sx   <= $signed(SXW'(r_out_col)) - SXW'(HALF);
            r_sx0  <= $signed(SXW'(r_out_col)) - SXW'(HALF);
            r_sy   <= $signed(SYW'(r_out_row)) - SYW'(HALF);
            r_cph  <= st_cph;
            r_cph0 <= st_cph;
            r_rph  <= st_rph;
            r_slot <= st_slot;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cmd.scan) begin
                if (r_dx == DW'(WINDOW - 1)) begin
                    r_dx   <= '0;
                    r_dy   <= r_dy + DW'(1);
                    r_sx   <= r_sx0;
                    r_cph  <= r_cph0;
                    r_sy   <= r_sy + SYW'(1);
                    r_rph  <= inc_ph(r_rph, pr_eff);
                    r_slot <= inc_sl(r_slot);
                end else begin
                    r_dx  <= r_dx + DW'(1);
                    r_sx  <= r_sx + SXW'(1);
                    r_cph <= inc_ph(r_cph, pc_eff);
                end
            end
            if (r_tap_go && r_tap_v && (r_rdata != '0)) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_tap_col == 2'(k)) begin
                        r_sum[k] <= r_sum[k] + SUMW'(r_rdata);
                        r_cnt[k] <= r_cnt[k] + CNTW'(1);
                    end
                end
            end
        end
        r_tap_v   <= tap_in;
        r_tap_col <= tap_col;

        if (i_cmd.div_start) begin
            r_rem  <= r_sum[0];
            r_q    <= '0;
            r_bit  <= 3'd7;
            r_dcol <= 2'd0;
        end else if (i_cmd.div) begin
            if (r_bit == 3'd0) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_dcol == 2'(k)) r_res[k] <= (cnt_sel == '0) ? '0 : q_new;
                end
                r_q   <= '0;
                r_bit <= 3'd7;
                if (r_dcol != 2'd2) begin
                    r_dcol <= r_dcol + 2'd1;
                    r_rem  <= (r_dcol == 2'd0) ? r_sum[1] : r_sum[2];
                end
            end else begin
                r_q   <= q_new;
                r_rem <= rem_new;
                r_bit <= r_bit - 3'd1;
            end
        end

        if (i_cmd.load) begin
            r_odata <= {r_res[2], r_res[1], r_res[0]};
            r_olast <= ((WV'(r_out_col) + WV'(1)) >= w_eff)
                    && ((ROWV_W'(r_out_row) + ROWV_W'(1)) >= h_eff);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw       <= FW_RESET;
            r_fh       <= FH_RESET;
            r_pcols    <= PER_RESET;
            r_prows    <= PER_RESET;
            r_cells    <= CELLS_RESET;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_done     <= 1'b0;
            r_lag      <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_oc_ph    <= '0;
            r_or_ph    <= '0;
            r_ov       <= 1'b0;
            r_tap_go   <= 1'b0;
        end else begin
            r_tap_go <= i_cmd.scan;
            if (i_cmd.load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;

            if (wr_en) begin
                r_lag <= r_lag + LW'(1);
                if (in_col_wrap) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + ROW_W'(1);
                    r_in_slot <= inc_sl(r_in_slot);
                    if (in_row_wrap) r_done <= 1'b1;
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end

            if (i_cmd.load) begin
                r_lag <= r_lag - LW'(1);
                if ((WV'(r_out_col) + WV'(1)) >= w_eff) begin
                    r_out_col <= '0;
                    r_oc_ph   <= '0;
                    if ((ROWV_W'(r_out_row) + ROWV_W'(1)) >= h_eff) begin
                        // frame complete, start over
                        r_in_col   <= '0;
                        r_in_row   <= '0;
                        r_in_slot  <= '0;
                        r_done     <= 1'b0;
                        r_lag      <= '0;
                        r_out_row  <= '0;
                        r_out_slot <= '0;
                        r_or_ph    <= '0;
                    end else begin
                        r_out_row  <= r_out_row + ROW_W'(1);
                        r_out_slot <= inc_sl(r_out_slot);
                        r_or_ph    <= inc_ph(r_or_ph, pr_eff);
                    end
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                    r_oc_ph   <= inc_ph(r_oc_ph, pc_eff);
                end
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_fw    <= i_cfg_data[FW_W-1:0];
                    CFG_HEIGHT: r_fh    <= i_cfg_data[FH_W-1:0];
                    CFG_PCOLS:  r_pcols <= i_cfg_data[PER_W-1:0];
                    CFG_PROWS:  r_prows <= i_cfg_data[PER_W-1:0];
                    CFG_CELLS:  r_cells <= i_cfg_data;
                    default: ;
                endcase
                if (32'(i_cfg_index) <= 32'(CFG_CELLS)) begin
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_slot  <= '0;
                    r_done     <= 1'b0;
                    r_lag      <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_slot <= '0;
                    r_oc_ph    <= '0;
                    r_or_ph    <= '0;
                end
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_odata;
    assign o_out_last  = r_olast;

endmodule

[rtl/bayer_neighborhood_demosaic.sv]
// sequence: a request that completes no pixel is taken in IDLE and leaves s_axis ready; one that
//   does has its pixel on m_axis after the scan, drain, load, divide and output states
// input side: such a request holds s_axis until its pixel is loaded for output (one line store
//   read per tap, one quotient bit per divider step for each colour), longer while an earlier pixel waits
// reset: synchronous active-low; registers return to their defaults and counters
//   clear, the line store keeps its contents and needs no clearing pass
module bayer_neighborhood_demosaic #(
    parameter int MAX_WIDTH  = 2048,
    parameter int WINDOW     = 3,
    parameter int MAX_PERIOD = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bnd_pkg::PIX_W-1:0]     s_axis_tdata,   // raw_pixel
    input  logic                          s_axis_tuser,   // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [3*bnd_pkg::PIX_W-1:0]   m_axis_tdata,   // red, green, blue
    output logic                          m_axis_tlast,   // frame_end
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bnd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bnd_pkg::CELLS_W-1:0]   i_cfg_data
);
    import bnd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bnd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bnd_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .WINDOW     (WINDOW),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (s_axis_tuser),
        .i_pixel     (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

[rtl/bnd_checker.sv]
module bnd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [3*bnd_pkg::PIX_W-1:0]   m_axis_tdata,
    input logic                          m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // a new result only appears while the input side is busy
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while input side idle");

    // nothing pending right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n |-> !m_axis_tvalid)
        else $error("result valid after reset");

    // the input side is open again when a new result appears
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("input side not reopened after result");

endmodule

bind bayer_neighborhood_demosaic bnd_checker u_bnd_checker (.*);
